// ----- sv/nsr_pkg.sv -----
package nsr_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int MAX_ITERATIONS = 32;

    localparam int IN_W   = 32;
    localparam int ROOT_W = 24;
    // A nonnegative radicand keeps 31 significant bits.
    localparam int A_W    = IN_W - 1;
    // Dividend (radicand << FRAC_BITS) width; the estimate never exceeds it.
    localparam int DW     = A_W + FRAC_BITS;
    localparam int XW     = DW;
    localparam int CNT_W  = $clog2(DW);
    localparam int STEP_W = $clog2(MAX_ITERATIONS + 1);
    localparam int PC_W   = 3;

    localparam logic [XW-1:0] ROOT_MAX = XW'({ROOT_W{1'b1}});

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_INIT   = 3'd1,
        OP_DSTART = 3'd2,
        OP_DSTEP  = 3'd3,
        OP_UPDATE = 3'd4,
        OP_DIFF   = 3'd5,
        OP_NOP    = 3'd6,
        OP_EMIT   = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        C_NONE     = 3'd0,
        C_NO_IN    = 3'd1,
        C_SPECIAL  = 3'd2,
        C_DIV_BUSY = 3'd3,
        C_AGAIN    = 3'd4,
        C_OUT_BUSY = 3'd5
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic special;
        logic div_busy;
        logic again;
    } t_dp_stat;

    typedef struct packed {
        t_dp_stat dp;
        logic     in_take;
        logic     out_busy;
    } t_seq_stat;

    localparam logic [PC_W-1:0] PC_IDLE   = PC_W'(0);
    localparam logic [PC_W-1:0] PC_DSTART = PC_W'(2);
    localparam logic [PC_W-1:0] PC_DSTEP  = PC_W'(3);
    localparam logic [PC_W-1:0] PC_EMIT   = PC_W'(7);

    // Microprogram. A step whose condition is false falls through to the
    // next address; the emit step sits last so that falling through wraps
    // back to idle.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        begin
            case (pc)
                PC_W'(0): w = '{OP_LOAD,   C_NO_IN,    PC_IDLE};
                PC_W'(1): w = '{OP_INIT,   C_SPECIAL,  PC_EMIT};
                PC_W'(2): w = '{OP_DSTART, C_NONE,     PC_IDLE};
                PC_W'(3): w = '{OP_DSTEP,  C_DIV_BUSY, PC_DSTEP};
                PC_W'(4): w = '{OP_UPDATE, C_NONE,     PC_IDLE};
                PC_W'(5): w = '{OP_DIFF,   C_NONE,     PC_IDLE};
                PC_W'(6): w = '{OP_NOP,    C_AGAIN,    PC_DSTART};
                PC_W'(7): w = '{OP_EMIT,   C_OUT_BUSY, PC_EMIT};
                default:  w = '{OP_NOP,    C_NONE,     PC_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

// ----- sv/nsr_seq.sv -----
module nsr_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nsr_pkg::t_seq_stat i_stat,
    output nsr_pkg::t_uword    o_ctrl
);
    import nsr_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w;
    logic            jump;

    always_comb begin
        w = ucode(r_pc);
        case (w.cond)
            C_NONE:     jump = 1'b0;
            C_NO_IN:    jump = !i_stat.in_take;
            C_SPECIAL:  jump = i_stat.dp.special;
            C_DIV_BUSY: jump = i_stat.dp.div_busy;
            C_AGAIN:    jump = i_stat.dp.again;
            C_OUT_BUSY: jump = i_stat.out_busy;
            default:    jump = 1'b0;
        endcase
        n_pc = jump ? w.target : r_pc + PC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w;

endmodule

// ----- sv/nsr_datapath.sv -----
module nsr_datapath (
    input  logic                        i_clk,
    input  nsr_pkg::t_op                i_op,
    input  logic                        i_load,
    input  logic [nsr_pkg::IN_W-1:0]    i_radicand,
    input  logic [nsr_pkg::IN_W-1:0]    i_tolerance,
    output nsr_pkg::t_dp_stat           o_stat,
    output logic [nsr_pkg::ROOT_W-1:0]  o_root,
    output logic                        o_error
);
    import nsr_pkg::*;

    logic [A_W-1:0]       r_a;
    logic [FRAC_BITS-1:0] r_tol;
    logic                 r_bad;
    logic                 r_zero;
    logic [XW-1:0]        r_x;
    logic [XW-1:0]        r_xold;
    logic [XW-1:0]        r_diff;
    logic [DW-1:0]        r_q;
    logic [XW:0]          r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic [STEP_W-1:0]    r_steps;

    logic                 in_bad;
    logic [XW:0]          rem_shift;
    logic                 rem_ge;
    logic [XW:0]          sum;
    logic [XW-1:0]        nx;
    logic [XW-1:0]        x0;

    always_comb begin
        in_bad = i_radicand[IN_W-1] || i_tolerance[IN_W-1]
              || (i_tolerance == '0) || (i_tolerance[IN_W-2:FRAC_BITS] != '0);
        x0 = XW'(r_a[A_W-1:1]);
        if (x0 == '0) begin
            x0 = XW'(1);
        end
        // Restoring division, one quotient bit per step.
        rem_shift = {r_rem[XW-1:0], r_q[DW-1]};
        rem_ge    = rem_shift >= {1'b0, r_x};
        sum = {1'b0, r_x} + {1'b0, r_q};
        nx  = sum[XW:1];
        if (nx == '0) begin
            nx = XW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                if (i_load) begin
                    r_a    <= i_radicand[A_W-1:0];
                    r_tol  <= i_tolerance[FRAC_BITS-1:0];
                    r_bad  <= in_bad;
                    r_zero <= (i_radicand == '0);
                end
            end
            OP_INIT: begin
                r_x     <= x0;
                r_steps <= '0;
            end
            OP_DSTART: begin
                r_q   <= {r_a, {FRAC_BITS{1'b0}}};
                r_rem <= '0;
                r_cnt <= CNT_W'(DW - 1);
            end
            OP_DSTEP: begin
                r_rem <= rem_ge ? rem_shift - {1'b0, r_x} : rem_shift;
                r_q   <= {r_q[DW-2:0], rem_ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            OP_UPDATE: begin
                r_xold <= r_x;
                r_x    <= nx;
            end
            OP_DIFF: begin
                r_diff  <= (r_x >= r_xold) ? r_x - r_xold : r_xold - r_x;
                r_steps <= r_steps + STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_stat.special  = r_bad || r_zero;
    assign o_stat.div_busy = (r_cnt != '0);
    assign o_stat.again    = (r_diff >= XW'(r_tol))
                          && (r_steps < STEP_W'(MAX_ITERATIONS));

    always_comb begin
        if (r_bad || r_zero) begin
            o_root = '0;
        end else if (r_x > ROOT_MAX) begin
            o_root = {ROOT_W{1'b1}};
        end else begin
            o_root = r_x[ROOT_W-1:0];
        end
    end

    assign o_error = r_bad;

endmodule

// ----- sv/newton_square_root.sv -----
// Channel   Direction  Beat contents (lowest bit first)
// s_axis    in         tdata: radicand[31:0], tolerance[63:32]
// m_axis    out        tdata: root[23:0]; tuser: error
//
// Each beat is loaded and given a start value, then runs n Newton steps,
// where n is 1 to 32. A step runs the bit-serial restoring divider for one
// quotient, then update, difference and test. Rejected or zero radicands
// skip the Newton steps and go straight to emit. Reset is synchronous and
// active low; it returns the microprogram to its idle step and empties the
// output register. A stalled output holds its beat while the next input
// beat may already be taken and worked on.
module newton_square_root (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // radicand [31:0], tolerance [63:32]
    input  logic [2*nsr_pkg::IN_W-1:0]     i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // root [23:0]
    output logic [nsr_pkg::ROOT_W-1:0]     o_m_axis_tdata,
    // error [0]
    output logic                           o_m_axis_tuser
);
    import nsr_pkg::*;

    t_uword              ctrl;
    t_seq_stat           seq_stat;
    t_dp_stat            dp_stat;
    logic [ROOT_W-1:0]   dp_root;
    logic                dp_error;
    logic                in_take;
    logic                out_busy;
    logic                out_load;

    logic                r_out_valid;
    logic [ROOT_W-1:0]   r_root;
    logic                r_error;

    // The sequencer sits in its load step exactly when it can take a beat.
    assign o_s_axis_tready = (ctrl.op == OP_LOAD);
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    // The output register is free when empty or being drained this cycle.
    assign out_busy = r_out_valid && !i_m_axis_tready;
    assign out_load = (ctrl.op == OP_EMIT) && !out_busy;

    assign seq_stat.dp       = dp_stat;
    assign seq_stat.in_take  = in_take;
    assign seq_stat.out_busy = out_busy;

    nsr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (seq_stat),
        .o_ctrl  (ctrl)
    );

    nsr_datapath u_dp (
        .i_clk       (i_clk),
        .i_op        (ctrl.op),
        .i_load      (in_take),
        .i_radicand  (i_s_axis_tdata[IN_W-1:0]),
        .i_tolerance (i_s_axis_tdata[2*IN_W-1:IN_W]),
        .o_stat      (dp_stat),
        .o_root      (dp_root),
        .o_error     (dp_error)
    );

    // Output register: the finished root waits here so that the datapath
    // can return to idle and accept the next beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_root  <= dp_root;
            r_error <= dp_error;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_root;
    assign o_m_axis_tuser  = r_error;

endmodule

// ----- sv/nsr_checker.sv -----
module nsr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [nsr_pkg::ROOT_W-1:0]  o_m_axis_tdata,
    input logic                        o_m_axis_tuser
);
    import nsr_pkg::*;

    logic in_take;
    assign in_take = i_s_axis_tvalid && o_s_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("error beat carries a nonzero root");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !o_s_axis_tready)
        else $error("second beat taken while one is in work");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !$rose(o_m_axis_tvalid))
        else $error("result appeared one cycle after input");

endmodule

bind newton_square_root nsr_checker u_nsr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ----- verif/newton_root_checker.sv -----
module newton_root_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // radicand [31:0], tolerance [63:32]
    input  logic [63:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // root [23:0]
    input  logic [23:0] i_m_tdata,
    // error [0]
    input  logic        i_m_tuser,
    output int          o_fail_count,
    output int          o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [nsr_pkg::ROOT_W-1:0] root;
        logic                       error;
    } t_root_result;

    t_root_result expected_roots[$];

    // Truncating Newton iteration on the raw fixed-point values.
    function automatic t_root_result predict_root(input logic [31:0] radicand,
                                                  input logic [31:0] tolerance);
        logic [63:0]  scaled;
        logic [63:0]  est;
        logic [63:0]  next_est;
        logic [63:0]  change;
        int           steps;
        t_root_result res;
        res.root  = '0;
        res.error = 1'b0;
        if (radicand[31] || tolerance[31] || tolerance == 32'd0 ||
            {32'd0, tolerance} >= (64'd1 << nsr_pkg::FRAC_BITS)) begin
            res.error = 1'b1;
            return res;
        end
        if (radicand == 32'd0)
            return res;
        scaled = {32'd0, radicand} << nsr_pkg::FRAC_BITS;
        est    = {32'd0, radicand} >> 1;
        if (est == 64'd0)
            est = 64'd1;
        steps = 0;
        do begin
            next_est = (est + scaled / est) >> 1;
            if (next_est == 64'd0)
                next_est = 64'd1;
            change = (next_est >= est) ? next_est - est : est - next_est;
            est    = next_est;
            steps++;
        end while (change >= {32'd0, tolerance} && steps < nsr_pkg::MAX_ITERATIONS);
        res.root = (est > 64'hFF_FFFF) ? '1 : est[nsr_pkg::ROOT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_root_result want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_roots.size() == 0) begin
                    $display("%0t ns: unexpected result beat, expected none, got root %h error %b",
                             $time, i_m_tdata, i_m_tuser);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_roots.pop_front();
                    if (want.root !== i_m_tdata || want.error !== i_m_tuser) begin
                        if (want.root !== i_m_tdata)
                            $display("%0t ns: root mismatch, expected %h, got %h",
                                     $time, want.root, i_m_tdata);
                        if (want.error !== i_m_tuser)
                            $display("%0t ns: error flag mismatch, expected %b, got %b",
                                     $time, want.error, i_m_tuser);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_roots.push_back(predict_root(i_s_tdata[31:0], i_s_tdata[63:32]));
            o_pending <= expected_roots.size();
        end else begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Stimulus and verdict for the Newton-Raphson square root block. The checker
// beside the block watches both streams, predicts every result and counts
// the failures; this module only produces beats, back-pressure and the
// final message.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_BEATS = 580;
    // The slowest item runs all 32 Newton steps; the drain wait covers it.
    localparam int DRAIN_CYCLES = 2000;
    localparam logic [31:0] ONE_RAW = 32'd1 << nsr_pkg::FRAC_BITS;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // radicand [31:0], tolerance [63:32]
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // root [23:0]
    logic [23:0] m_tdata;
    // error [0]
    logic        m_tuser;

    int fail_count;
    int pending;

    // When set, the matching side runs without any idle cycles.
    logic send_burst = 1'b0;
    logic recv_burst = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    newton_square_root dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    newton_root_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offers one beat. It is entered at a falling edge and returns at the
    // falling edge after the beat was taken, so that tvalid stays high into
    // the next beat when no gap is drawn, and tvalid is never lowered and
    // raised within one time step.
    task automatic send_beat(input logic [31:0] radicand, input logic [31:0] tolerance);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tolerance, radicand};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // A tolerance strictly between zero and one; the extremes come often.
    function automatic logic [31:0] legal_tolerance();
        logic [31:0] tol;
        case ($urandom_range(0, 3))
            0:       tol = 32'd1;
            1:       tol = ONE_RAW - 32'd1;
            2:       tol = $urandom_range(1, 15);
            default: tol = $urandom_range(1, ONE_RAW - 1);
        endcase
        return tol;
    endfunction

    // A radicand the block accepts. Besides plain random values there are
    // exact squares, values near the top of the range, and values for which
    // the truncated iteration swings by one LSB forever, so that the step
    // limit ends it.
    function automatic logic [31:0] legal_radicand();
        logic [31:0] rad;
        logic [31:0] m;
        case ($urandom_range(0, 5))
            0: rad = $urandom >> 1;
            1: rad = $urandom_range(1, 255);
            2: rad = $urandom_range(1, 32'h00FF_FFFF);
            3: begin
                m   = $urandom_range(1, 46340);
                rad = m * m;
            end
            4: begin
                // (m * 2^15 +- 1)^2 - 1 is a multiple of 2^16.
                m   = $urandom_range(1, 361);
                rad = $urandom_range(0, 1) ? m * (m * 32'd16384 + 32'd1)
                                           : m * (m * 32'd16384 - 32'd1);
            end
            default: rad = $urandom_range(32'h7FFF_0000, 32'h7FFF_FFFF);
        endcase
        return rad;
    endfunction

    // Draws one random beat: mostly legal items, the rest rejected ones
    // with random content and a few zero radicands.
    task automatic send_random_beat();
        int          pick;
        logic [31:0] rad;
        logic [31:0] tol;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            rad = $urandom;
            case ($urandom_range(0, 3))
                0:       tol = 32'd0;
                1:       tol = $urandom | 32'h8000_0000;
                2:       tol = ONE_RAW;
                default: tol = $urandom_range(ONE_RAW, 32'h7FFF_FFFF);
            endcase
        end else if (pick < 17) begin
            rad = $urandom | 32'h8000_0000;
            tol = legal_tolerance();
        end else if (pick < 20) begin
            rad = 32'd0;
            tol = $urandom_range(0, 1) ? legal_tolerance() : $urandom;
        end else begin
            rad = legal_radicand();
            tol = legal_tolerance();
        end
        send_beat(rad, tol);
    endtask

    // Result side: a random stall before each result, and now and then a
    // stretch with tready held high.
    initial begin
        int stall;
        int served;
        served = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (served % 30 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            stall = recv_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            served++;
            @(negedge clk);
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: zero radicand, the tiny radicand whose start value
        // is zero, the range extremes, exact squares, the endless one-LSB
        // swing, and each way of rejecting an item.
        send_beat(32'd0, 32'd1);
        send_beat(32'd0, ONE_RAW - 32'd1);
        send_beat(32'd1, 32'd1);
        send_beat(32'd2, 32'd1);
        send_beat(32'd3, ONE_RAW - 32'd1);
        send_beat(ONE_RAW, 32'd1);
        send_beat(32'd4 * ONE_RAW, 32'd1);
        send_beat(32'h7FFF_FFFF, 32'd1);
        send_beat(32'h7FFF_FFFF, ONE_RAW - 32'd1);
        send_beat(32'd65534, 32'd1);
        send_beat(32'd16383, 32'd1);
        send_beat(32'd16383, 32'd2);
        send_beat(32'h5555_5555, 32'h0000_AAAA);
        send_beat(32'h2AAA_AAAA, 32'h0000_5555);
        send_beat(32'h8000_0000, 32'd1);
        send_beat(32'hFFFF_FFFF, 32'd1);
        send_beat(32'd100, 32'd0);
        send_beat(32'd100, ONE_RAW);
        send_beat(32'd100, 32'hFFFF_FFFF);
        send_beat(32'd100, 32'h8000_0000);
        send_beat(32'd100, 32'h7FFF_FFFF);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(32'd0, 32'd0);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 40 == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            send_random_beat();
        end
        s_tvalid <= 1'b0;

        // Let every outstanding result arrive, then watch a while longer
        // for stray beats.
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("newton_square_root regression: pass");
        else
            $display("newton_square_root regression: fail");
        $finish;
    end

    // Safety net: several times the slowest legal run.
    initial begin
        #(64'd50_000_000);
        $display("newton_square_root regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/nsr_pkg.sv
sv/nsr_seq.sv
sv/nsr_datapath.sv
sv/newton_square_root.sv
sv/nsr_checker.sv
verif/newton_root_checker.sv
verif/testbench.sv
